// ===== rtl/ilt_pkg.sv =====
// Package: shared types, constants and character classes for the line tokenizer.
`timescale 1ns / 1ps
package ilt_pkg;

	localparam int unsigned LINE_MAX = 1024;
	localparam int unsigned START_W  = $clog2(LINE_MAX);
	localparam int unsigned POS_W    = START_W + 1;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned KIND_W   = 3;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = FIFO_AW + 1;

	localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3D;
	localparam logic [CHAR_W-1:0] CH_LBR  = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBR  = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_USCR = 8'h5F;

	typedef enum logic [KIND_W-1:0] {
		KIND_END = 3'd0,
		KIND_LBR = 3'd1,
		KIND_RBR = 3'd2,
		KIND_EQ  = 3'd3,
		KIND_ID  = 3'd4,
		KIND_VAL = 3'd5
	} token_kind_t;

	typedef struct packed {
		token_kind_t          kind;
		logic [START_W-1:0]   start;
		logic [POS_W-1:0]     length;
		logic                 last;
	} token_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
		return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
	endfunction

	function automatic logic is_ident_char(input logic [CHAR_W-1:0] ch);
		return ((ch >= 8'h30) && (ch <= 8'h39)) ||
		       ((ch >= 8'h41) && (ch <= 8'h5A)) ||
		       ((ch >= 8'h61) && (ch <= 8'h7A)) ||
		       (ch == CH_USCR) || (ch == CH_DASH);
	endfunction

endpackage

// ===== rtl/ilt_if.sv =====
// Interfaces: character input channel and token output channel.
`timescale 1ns / 1ps
interface ilt_char_if;
	import ilt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface ilt_token_if;
	import ilt_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  token_kind;
	logic [START_W-1:0] token_start;
	logic [POS_W-1:0]   token_length;
	logic               run_last;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output run_last, input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_length, input run_last, output ready);
endinterface

// ===== rtl/ini_line_tokenizer_top.sv =====
// Top level: streaming INI line tokenizer with token output queue.
//
// Usage:
//   chars  - one character per request; a zero byte ends the line.
//   tokens - one token per request: kind, start offset, length and a
//            run_last flag on the final token caused by a character.
//   A character is registered on acceptance and classified in the next
//   cycle against the line state (greedy flag, open token, position).
//   That cycle yields zero, one or two tokens, which are written into an
//   eight-entry queue; the queue head drives the tokens channel.
// Path: a token reaches tokens through the input register and then the
//   queue write.
// Throughput: one character per cycle. The input side takes a character
//   while the queue has room for the worst case of two tokens from it and
//   two from the character still in the input register.
// Reset: arst_n clears the line state, input register valid and queue
//   pointers; the block comes up ready at line offset 0.
// Stall: when the receiver holds tokens.ready low the queue fills and the
//   input side drops ready; no token is lost or repeated. Positions past
//   the line limit saturate onto the last offset.
`timescale 1ns / 1ps
module ini_line_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	ilt_char_if.sink           chars,
	ilt_token_if.source        tokens
);
	import ilt_pkg::*;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;

	// line state
	logic               greedy_q;
	logic               open_q;
	logic               open_val_q;
	logic [START_W-1:0] open_start_q;
	logic [POS_W-1:0]   pos_q;

	// token queue
	token_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	logic               in_take;
	logic               out_take;

	// room for two from the registered character plus two from this one
	assign chars.ready = ({1'b0, cnt_q} + (valid_s1 ? 5'd2 : 5'd0) + 5'd2)
		<= 5'(FIFO_DEPTH);
	assign in_take  = chars.valid && chars.ready;
	assign out_take = tokens.valid && tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1 <= chars.char_code;
		end
	end

	// classification of the registered character
	logic [START_W-1:0] pos_clamp;
	logic [POS_W-1:0]   open_len;
	logic               ch_nul;
	logic               ch_blank;
	logic               ch_ident;
	token_t             tok0;
	token_t             tok1;
	logic [1:0]         push_n;
	logic               greedy_d;
	logic               open_d;
	logic               open_val_d;
	logic [START_W-1:0] open_start_d;
	logic [POS_W-1:0]   pos_d;

	assign pos_clamp = (pos_q == POS_W'(LINE_MAX)) ? START_W'(LINE_MAX - 1)
		: pos_q[START_W-1:0];
	assign open_len  = pos_q - {1'b0, open_start_q};
	assign ch_nul    = (char_s1 == CH_NUL);
	assign ch_blank  = is_blank(char_s1);
	assign ch_ident  = is_ident_char(char_s1);

	always_comb begin
		token_t atom;
		logic   have_atom;
		logic   close_id;

		tok0         = '0;
		tok1         = '0;
		push_n       = 2'd0;
		greedy_d     = greedy_q;
		open_d       = open_q;
		open_val_d   = open_val_q;
		open_start_d = open_start_q;
		pos_d        = (pos_q == POS_W'(LINE_MAX)) ? pos_q : pos_q + 1'b1;
		atom         = '0;
		have_atom    = 1'b0;
		close_id     = 1'b0;

		if (ch_nul) begin
			// end of line: flush open token, then END, then clear
			atom.kind   = KIND_END;
			atom.start  = pos_clamp;
			atom.length = '0;
			atom.last   = 1'b1;
			if (open_q) begin
				tok0.kind   = open_val_q ? KIND_VAL : KIND_ID;
				tok0.start  = open_start_q;
				tok0.length = open_len;
				tok1        = atom;
				push_n      = 2'd2;
			end else begin
				tok0   = atom;
				push_n = 2'd1;
			end
			greedy_d     = 1'b0;
			open_d       = 1'b0;
			open_val_d   = 1'b0;
			open_start_d = '0;
			pos_d        = '0;
		end else if (!(open_q && (open_val_q || ch_ident))) begin
			close_id = open_q;
			if (close_id) begin
				open_d = 1'b0;
			end
			if (!ch_blank) begin
				atom.start  = pos_clamp;
				atom.length = POS_W'(1);
				atom.last   = 1'b1;
				if (greedy_q) begin
					open_d       = 1'b1;
					open_val_d   = 1'b1;
					open_start_d = pos_clamp;
				end else if (char_s1 == CH_LBR) begin
					atom.kind = KIND_LBR;
					have_atom = 1'b1;
				end else if (char_s1 == CH_RBR) begin
					atom.kind = KIND_RBR;
					have_atom = 1'b1;
				end else if (char_s1 == CH_EQ) begin
					atom.kind = KIND_EQ;
					have_atom = 1'b1;
					greedy_d  = 1'b1;
				end else begin
					open_d       = 1'b1;
					open_val_d   = 1'b0;
					open_start_d = pos_clamp;
				end
			end
			if (close_id) begin
				tok0.kind   = KIND_ID;
				tok0.start  = open_start_q;
				tok0.length = open_len;
				tok0.last   = !have_atom;
				tok1        = atom;
				push_n      = have_atom ? 2'd2 : 2'd1;
			end else if (have_atom) begin
				tok0   = atom;
				push_n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			greedy_q     <= 1'b0;
			open_q       <= 1'b0;
			open_val_q   <= 1'b0;
			open_start_q <= '0;
			pos_q        <= '0;
		end else if (valid_s1) begin
			greedy_q     <= greedy_d;
			open_q       <= open_d;
			open_val_q   <= open_val_d;
			open_start_q <= open_start_d;
			pos_q        <= pos_d;
		end
	end

	// token queue
	logic [1:0] push_eff;
	assign push_eff = valid_s1 ? push_n : 2'd0;

	always_ff @(posedge clk) begin
		if (push_eff != 2'd0) begin
			fifo_q[wr_ptr_q] <= tok0;
		end
		if (push_eff == 2'd2) begin
			fifo_q[wr_ptr_q + 1'b1] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_eff);
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push_eff) - FIFO_CW'(out_take);
		end
	end

	token_t head;
	assign head                = fifo_q[rd_ptr_q];
	assign tokens.valid        = (cnt_q != '0);
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.run_last     = head.last;

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} + 5'(push_eff)) <= 5'(FIFO_DEPTH))
		else $error("token queue overflow");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LINE_MAX))
		else $error("line position beyond limit");

	a_eol_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ch_nul |=> (pos_q == '0) && !open_q && !greedy_q)
		else $error("line state not cleared at end of line");

	a_open_before_pos: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> ({1'b0, open_start_q} < pos_q))
		else $error("open token starts at or after current position");

endmodule

// ===== tb/tb_ini_line_tokenizer_top.sv =====
// Testbench for the INI line tokenizer: directed table, random lines, scoreboard check.
`timescale 1ns / 1ps
module tb_ini_line_tokenizer_top;
	import ilt_pkg::*;

	localparam int unsigned CLK_HALF    = 6;
	localparam int unsigned RESET_LEN   = 8;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_LEN   = 24;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned PHASE_ITEMS = 180;
	localparam int unsigned MAX_REPORTS = 10;
	localparam token_t      NO_TOK      = '0;

	// Receiver stall styles, switched at random segment boundaries.
	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_BEAT,
		SINK_SLOW
	} sink_mode_t;

	// Random line shapes.
	typedef enum int {
		LN_SECTION,
		LN_PAIR,
		LN_NOISE,
		LN_JUMBLE,
		LN_BLANK
	} line_kind_t;

	// One character request; typed rows carry their expected tokens.
	typedef struct {
		logic [CHAR_W-1:0] ch;
		bit                typed;
		int                n;
		token_t            t0;
		token_t            t1;
	} char_req_t;

	logic clk;
	logic arst_n;

	ilt_char_if  chars_if ();
	ilt_token_if tokens_if ();

	ini_line_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.tokens (tokens_if)
	);

	// Shadow line state of the lexer.
	bit          in_greedy;
	bit          tok_open;
	bit          open_value;
	int unsigned open_start;
	int unsigned line_pos;

	char_req_t   char_queue[$];
	token_t      pending_tokens[$];
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned burst_left;
	bit          long_hold;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Hard stop in case the block wedges.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic token_t tok(token_kind_t k, int unsigned s, int unsigned l, bit lst);
		token_t t;
		t.kind   = k;
		t.start  = START_W'(s);
		t.length = POS_W'(l);
		t.last   = lst;
		return t;
	endfunction

	function automatic bit blank_char(logic [CHAR_W-1:0] ch);
		return ch == CH_SP || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
	endfunction

	function automatic bit word_char(logic [CHAR_W-1:0] ch);
		if (ch >= "0" && ch <= "9")
			return 1'b1;
		if (ch >= "A" && ch <= "Z")
			return 1'b1;
		if (ch >= "a" && ch <= "z")
			return 1'b1;
		return ch == CH_USCR || ch == CH_DASH;
	endfunction

	// Advance the shadow lexer by one character; returns the token count.
	function automatic int lex_char(input logic [CHAR_W-1:0] ch, output token_t r0,
			output token_t r1);
		token_t      slot[2];
		int          n;
		int unsigned here;
		bit          keep;
		n = 0;
		keep = 1'b0;
		slot[0] = NO_TOK;
		slot[1] = NO_TOK;
		// offsets past the line limit collapse onto the last one
		here = (line_pos < LINE_MAX) ? line_pos : LINE_MAX - 1;
		if (ch == CH_NUL) begin
			if (tok_open) begin
				slot[n] = tok(open_value ? KIND_VAL : KIND_ID, open_start,
					line_pos - open_start, 1'b0);
				n++;
			end
			slot[n] = tok(KIND_END, here, 0, 1'b0);
			n++;
			in_greedy  = 1'b0;
			tok_open   = 1'b0;
			open_value = 1'b0;
			open_start = 0;
			line_pos   = 0;
		end else begin
			if (tok_open) begin
				if (open_value || word_char(ch)) begin
					keep = 1'b1;
				end else begin
					// identifier ends; the character is then taken fresh
					slot[n] = tok(KIND_ID, open_start, line_pos - open_start, 1'b0);
					n++;
					tok_open = 1'b0;
				end
			end
			if (!keep && !blank_char(ch)) begin
				if (in_greedy) begin
					tok_open   = 1'b1;
					open_value = 1'b1;
					open_start = here;
				end else if (ch == CH_LBR) begin
					slot[n] = tok(KIND_LBR, here, 1, 1'b0);
					n++;
				end else if (ch == CH_RBR) begin
					slot[n] = tok(KIND_RBR, here, 1, 1'b0);
					n++;
				end else if (ch == CH_EQ) begin
					slot[n] = tok(KIND_EQ, here, 1, 1'b0);
					n++;
					in_greedy = 1'b1;
				end else begin
					tok_open   = 1'b1;
					open_value = 1'b0;
					open_start = here;
				end
			end
			if (line_pos < LINE_MAX)
				line_pos++;
		end
		if (n > 0)
			slot[n-1].last = 1'b1;
		r0 = slot[0];
		r1 = slot[1];
		return n;
	endfunction

	task automatic add_char(logic [CHAR_W-1:0] ch);
		char_req_t req;
		req = '{ch, 1'b0, 0, NO_TOK, NO_TOK};
		char_queue = {char_queue, req};
	endtask

	task automatic add_typed(logic [CHAR_W-1:0] ch, int n, token_t t0, token_t t1);
		char_req_t req;
		req = '{ch, 1'b1, n, t0, t1};
		char_queue = {char_queue, req};
	endtask

	function automatic logic [CHAR_W-1:0] rand_blank();
		case ($urandom_range(0, 3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] rand_word_char();
		case ($urandom_range(0, 3))
			0: return CHAR_W'("0" + $urandom_range(0, 9));
			1: return CHAR_W'("A" + $urandom_range(0, 25));
			2: return CHAR_W'("a" + $urandom_range(0, 25));
			default: return $urandom_range(0, 1) ? CH_USCR : CH_DASH;
		endcase
	endfunction

	task automatic add_pad();
		repeat ($urandom_range(0, 2))
			add_char(rand_blank());
	endtask

	// One random line, mostly well formed, ending in a zero byte.
	task automatic build_line();
		int         r;
		line_kind_t kind;
		r = $urandom_range(0, 9);
		kind = (r <= 2) ? LN_SECTION : (r <= 6) ? LN_PAIR : (r == 7) ? LN_NOISE :
			(r == 8) ? LN_JUMBLE : LN_BLANK;
		case (kind)
			LN_SECTION: begin
				add_pad();
				add_char(CH_LBR);
				add_pad();
				repeat ($urandom_range(1, 8))
					add_char(rand_word_char());
				add_pad();
				add_char(CH_RBR);
				add_pad();
			end
			LN_PAIR: begin
				add_pad();
				repeat ($urandom_range(1, 8))
					add_char(rand_word_char());
				add_pad();
				add_char(CH_EQ);
				add_pad();
				repeat ($urandom_range(0, 12))
					add_char(CHAR_W'($urandom_range(1, 255)));
			end
			LN_NOISE: begin
				repeat ($urandom_range(1, 12))
					add_char(CHAR_W'($urandom_range(1, 255)));
			end
			LN_JUMBLE: begin
				repeat ($urandom_range(1, 10)) begin
					case ($urandom_range(0, 4))
						0: add_char(CH_LBR);
						1: add_char(CH_RBR);
						2: add_char(CH_EQ);
						3: add_char(rand_blank());
						default: add_char($urandom_range(0, 1) ? rand_word_char() :
							CHAR_W'($urandom_range(33, 47)));
					endcase
				end
			end
			default: add_pad();
		endcase
		add_char(CH_NUL);
	endtask

	// Push the queued characters through the input channel in bursts.
	task automatic run_queue();
		char_req_t req;
		token_t    p0;
		token_t    p1;
		int        n;
		while (char_queue.size() != 0) begin
			req = char_queue.pop_front();
			if (burst_left == 0) begin
				repeat ($urandom_range(1, 8)) begin
					chars_if.valid <= 1'b0;
					@(posedge clk);
				end
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 12);
			end
			burst_left--;
			chars_if.valid     <= 1'b1;
			chars_if.char_code <= req.ch;
			do
				@(posedge clk);
			while (!chars_if.ready);
			n = lex_char(req.ch, p0, p1);
			if (req.typed) begin
				n  = req.n;
				p0 = req.t0;
				p1 = req.t1;
			end
			if (n > 0)
				pending_tokens = {pending_tokens, p0};
			if (n > 1)
				pending_tokens = {pending_tokens, p1};
		end
		chars_if.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
	endtask

	// Token scoreboard: every accepted token against the oldest expectation.
	always @(posedge clk) begin
		token_t want;
		if (arst_n && tokens_if.valid && tokens_if.ready) begin
			if (pending_tokens.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected token kind=%0d start=%0d len=%0d last=%0d",
						tokens_if.token_kind, tokens_if.token_start,
						tokens_if.token_length, tokens_if.run_last);
				mismatches++;
			end else begin
				want = pending_tokens.pop_front();
				if (tokens_if.token_kind !== want.kind ||
						tokens_if.token_start !== want.start ||
						tokens_if.token_length !== want.length ||
						tokens_if.run_last !== want.last) begin
					if (mismatches < MAX_REPORTS)
						$display("token mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
							want.kind, want.start, want.length, want.last,
							tokens_if.token_kind, tokens_if.token_start,
							tokens_if.token_length, tokens_if.run_last);
					mismatches++;
				end
			end
		end
	end

	// Receiver: rotating stall styles, plus one long hold-off on request.
	initial begin : token_sink
		int          seg;
		int unsigned tick;
		sink_mode_t  mode;
		seg  = 0;
		tick = 0;
		mode = SINK_OPEN;
		tokens_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				// queue fills, input side has to back off
				long_hold = 1'b0;
				repeat (HOLD_CYCLES) begin
					tokens_if.ready <= 1'b0;
					@(posedge clk);
				end
			end else begin
				if (seg == 0) begin
					mode = sink_mode_t'($urandom_range(0, 3));
					seg  = $urandom_range(20, 120);
				end
				seg--;
				tick++;
				case (mode)
					SINK_OPEN: tokens_if.ready <= 1'b1;
					SINK_COIN: tokens_if.ready <= 1'($urandom_range(0, 1));
					SINK_BEAT: tokens_if.ready <= (tick % 4) != 0;
					default:   tokens_if.ready <= $urandom_range(0, 3) == 0;
				endcase
				@(posedge clk);
			end
		end
	end

	// Main sequence: reset, directed table, two random phases, drain.
	initial begin : char_source
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= CH_NUL;
		mismatches  = 0;
		cycle_count = 0;
		burst_left  = 0;
		long_hold   = 1'b0;
		in_greedy   = 1'b0;
		tok_open    = 1'b0;
		open_value  = 1'b0;
		open_start  = 0;
		line_pos    = 0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows are read straight off the rules;
		// the rest go through the shadow lexer.
		// empty line right after reset: END alone at offset 0
		add_typed(CH_NUL, 1, tok(KIND_END, 0, 0, 1'b1), NO_TOK);
		add_typed(CH_LBR, 1, tok(KIND_LBR, 0, 1, 1'b1), NO_TOK);
		add_char("a");
		add_char("Z");
		// bracket closes the identifier: two tokens from one character
		add_typed(CH_RBR, 2, tok(KIND_ID, 1, 2, 1'b0), tok(KIND_RBR, 3, 1, 1'b1));
		add_char(CH_SP);
		add_char(CH_TAB);
		// high byte starts an identifier, then the odd identifier characters
		add_char(8'hFF);
		add_char(CH_USCR);
		add_char(CH_DASH);
		add_char("9");
		add_typed(CH_EQ, 2, tok(KIND_ID, 6, 4, 1'b0), tok(KIND_EQ, 10, 1, 1'b1));
		add_char(CH_CR);
		add_char(CH_LF);
		// value swallows blanks and atoms, trailing tab included
		add_char("v");
		add_char(CH_SP);
		add_char(CH_LBR);
		add_char(CH_EQ);
		add_char(CH_TAB);
		add_typed(CH_NUL, 2, tok(KIND_VAL, 13, 5, 1'b0), tok(KIND_END, 18, 0, 1'b1));
		// punctuation breaks identifiers into one-character runs
		add_char("!");
		add_char("#");
		add_char(8'h80);
		add_typed(CH_NUL, 2, tok(KIND_ID, 2, 1, 1'b0), tok(KIND_END, 3, 0, 1'b1));
		// stray bracket, then '=' twice: the second starts a value
		add_char(CH_RBR);
		add_char(CH_EQ);
		add_char(CH_EQ);
		add_char(CH_NUL);
		run_queue();
		wait_idle();

		// first random phase, with the long receiver hold-off
		long_hold = 1'b1;
		while (char_queue.size() < PHASE_ITEMS)
			build_line();
		run_queue();
		wait_idle();

		// second random phase
		while (char_queue.size() < PHASE_ITEMS)
			build_line();
		run_queue();
		wait_idle();

		// catch any stray tokens after the last expected one
		repeat (DRAIN_LEN) @(posedge clk);
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ilt_pkg.sv
rtl/ilt_if.sv
rtl/ini_line_tokenizer_top.sv
tb/tb_ini_line_tokenizer_top.sv
